// ===== rtl/rc4d_pkg.sv =====
// Shared types and constants for the RC4-drop stream cipher.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package rc4d_pkg;

    // Key store geometry.
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int KEY_CW    = KEY_AW + 1;

    // Permutation memory geometry.
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    // Configuration register.
    localparam int          DROP_W     = 16;
    localparam logic [15:0] DROP_RESET = 16'd1024;

    // Item commands.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_key;   // store a key byte, start setup on the last one
        logic accept_data;  // capture a data byte
        logic nokey_res;    // prepare a result for data seen before any key
        logic fill_step;    // write identity entry n, advance n
        logic ks_b;         // key schedule: update j, read S[j]
        logic ks_c;         // key schedule: write S[n]
        logic ks_d;         // key schedule: write S[j], advance n and k
        logic pr_a;         // keystream: advance i, read S[i]
        logic pr_b;         // keystream: update j, read S[j]
        logic pr_c;         // keystream: write S[i], read S[t]
        logic pr_d;         // keystream: write S[j]
        logic clr_ij;       // clear i and j after the key schedule
        logic res_save;     // park the keystream result
        logic out_load_ks;  // load the output stage from the live result
        logic out_load_res; // load the output stage from the parked result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_last;   // sweep index is at its last entry
        logic out_free; // output stage can take a beat this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/rc4d_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first: a read and a write to the same address return the old data.
// No dependencies.
`default_nettype none

module rc4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/rc4d_ctrl.sv =====
// Controller for the RC4-drop cipher: state machine, drop counter and
// configuration register. Depends on rc4d_pkg.
`default_nettype none

module rc4d_ctrl
    import rc4d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_cmd,
    input  wire logic              i_key_last,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [DROP_W-1:0] i_cfg_wr_data,
    input  wire t_dp_sts           i_sts,
    output logic                   o_in_stall,
    output t_dp_cmd                o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_KS_A = 4'd2;
    localparam logic [3:0] ST_KS_B = 4'd3;
    localparam logic [3:0] ST_KS_C = 4'd4;
    localparam logic [3:0] ST_KS_D = 4'd5;
    localparam logic [3:0] ST_DR_A = 4'd6;
    localparam logic [3:0] ST_DR_B = 4'd7;
    localparam logic [3:0] ST_DR_C = 4'd8;
    localparam logic [3:0] ST_DR_D = 4'd9;
    localparam logic [3:0] ST_PR_A = 4'd10;
    localparam logic [3:0] ST_PR_B = 4'd11;
    localparam logic [3:0] ST_PR_C = 4'd12;
    localparam logic [3:0] ST_PR_D = 4'd13;
    localparam logic [3:0] ST_HOLD = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [DROP_W-1:0] r_drop_count;
    logic [DROP_W-1:0] r_drop_left, n_drop_left;
    logic              r_key_done, n_key_done;
    logic              w_accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_drop_left = r_drop_left;
        n_key_done  = r_key_done;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_KEY) begin
                        o_cmd.accept_key = 1'b1;
                        if (i_key_last) begin
                            n_state = ST_FILL;
                        end
                    end else if (r_key_done) begin
                        o_cmd.accept_data = 1'b1;
                        n_state           = ST_PR_A;
                    end else begin
                        o_cmd.nokey_res = 1'b1;
                        n_state         = ST_HOLD;
                    end
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.n_last) begin
                    n_state = ST_KS_A;
                end
            end
            ST_KS_A: begin
                // The resting read addresses already point at S[n] and K[k].
                n_state = ST_KS_B;
            end
            ST_KS_B: begin
                o_cmd.ks_b = 1'b1;
                n_state    = ST_KS_C;
            end
            ST_KS_C: begin
                o_cmd.ks_c = 1'b1;
                n_state    = ST_KS_D;
            end
            ST_KS_D: begin
                o_cmd.ks_d = 1'b1;
                if (!i_sts.n_last) begin
                    n_state = ST_KS_A;
                end else begin
                    o_cmd.clr_ij = 1'b1;
                    n_drop_left  = r_drop_count;
                    if (r_drop_count == '0) begin
                        n_key_done = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_DR_A;
                    end
                end
            end
            ST_DR_A: begin
                o_cmd.pr_a = 1'b1;
                n_state    = ST_DR_B;
            end
            ST_DR_B: begin
                o_cmd.pr_b = 1'b1;
                n_state    = ST_DR_C;
            end
            ST_DR_C: begin
                o_cmd.pr_c = 1'b1;
                n_state    = ST_DR_D;
            end
            ST_DR_D: begin
                o_cmd.pr_d  = 1'b1;
                n_drop_left = r_drop_left - DROP_W'(1);
                if (r_drop_left == DROP_W'(1)) begin
                    n_key_done = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_DR_A;
                end
            end
            ST_PR_A: begin
                o_cmd.pr_a = 1'b1;
                n_state    = ST_PR_B;
            end
            ST_PR_B: begin
                o_cmd.pr_b = 1'b1;
                n_state    = ST_PR_C;
            end
            ST_PR_C: begin
                o_cmd.pr_c = 1'b1;
                n_state    = ST_PR_D;
            end
            ST_PR_D: begin
                o_cmd.pr_d = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.out_load_ks = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    o_cmd.res_save = 1'b1;
                    n_state        = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_res = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_key_done   <= 1'b0;
            r_drop_left  <= '0;
            r_drop_count <= DROP_RESET;
        end else begin
            r_state     <= n_state;
            r_key_done  <= n_key_done;
            r_drop_left <= n_drop_left;
            if (i_cfg_wr_en) begin
                r_drop_count <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rc4d_dp.sv =====
// Datapath for the RC4-drop cipher: permutation memory, key store, indices
// and the output stage. Depends on rc4d_pkg and rc4d_ram.
`default_nettype none

module rc4d_dp
    import rc4d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_key_last,
    input  wire logic       i_out_stall,
    output t_dp_sts         o_sts,
    output logic            o_out_valid,
    output logic [7:0]      o_byte_out,
    output logic            o_no_key
);

    // Permutation memory ports.
    logic               w_p_we;
    logic [PERM_AW-1:0] w_p_waddr;
    logic [7:0]         w_p_wdata;
    logic [PERM_AW-1:0] w_p_raddr;
    logic [7:0]         w_p_rdata;

    // Key store ports.
    logic               w_k_we;
    logic [7:0]         w_k_rdata;

    logic [7:0]         r_i, r_j, r_n;
    logic [KEY_AW-1:0]  r_k;
    logic [KEY_CW-1:0]  r_key_count, r_key_len;
    logic [KEY_CW-1:0]  w_count_inc;
    logic [7:0]         r_sa, r_sb, r_t;
    logic [7:0]         r_data;
    logic [7:0]         r_res;
    logic               r_res_nk;
    logic [7:0]         w_ks, w_ks_result;
    logic               w_key_room;

    rc4d_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    rc4d_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key (
        .i_clk   (i_clk),
        .i_we    (w_k_we),
        .i_waddr (r_key_count[KEY_AW-1:0]),
        .i_wdata (i_byte_in),
        .i_raddr (r_k),
        .o_rdata (w_k_rdata)
    );

    assign w_key_room  = (r_key_count < KEY_CW'(KEY_DEPTH));
    assign w_k_we      = i_cmd.accept_key && w_key_room;
    assign w_count_inc = w_key_room ? (r_key_count + KEY_CW'(1)) : r_key_count;

    // Read addresses of the permutation memory.
    always_comb begin
        priority if (i_cmd.ks_b) begin
            w_p_raddr = r_j + w_p_rdata + w_k_rdata;
        end else if (i_cmd.pr_a) begin
            w_p_raddr = r_i + 8'd1;
        end else if (i_cmd.pr_b) begin
            w_p_raddr = r_j + w_p_rdata;
        end else if (i_cmd.pr_c) begin
            w_p_raddr = r_sa + w_p_rdata;
        end else begin
            w_p_raddr = r_n;
        end
    end

    // Write port of the permutation memory.
    always_comb begin
        w_p_we    = 1'b1;
        priority if (i_cmd.fill_step) begin
            w_p_waddr = r_n;
            w_p_wdata = r_n;
        end else if (i_cmd.ks_c) begin
            w_p_waddr = r_n;
            w_p_wdata = w_p_rdata;
        end else if (i_cmd.pr_c) begin
            w_p_waddr = r_i;
            w_p_wdata = w_p_rdata;
        end else if (i_cmd.ks_d || i_cmd.pr_d) begin
            w_p_waddr = r_j;
            w_p_wdata = r_sa;
        end else begin
            w_p_we    = 1'b0;
            w_p_waddr = r_n;
            w_p_wdata = r_sa;
        end
    end

    // The memory read of S[t] saw the table before the swap, so the two
    // swapped entries are taken from the values held in registers.
    always_comb begin
        priority if (r_t == r_j) begin
            w_ks = r_sa;
        end else if (r_t == r_i) begin
            w_ks = r_sb;
        end else begin
            w_ks = w_p_rdata;
        end
    end
    assign w_ks_result = r_data ^ w_ks;

    assign o_sts.n_last   = (r_n == 8'hff);
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_key_len   <= KEY_CW'(1);
            r_k         <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept_key) begin
                if (i_key_last) begin
                    r_key_count <= '0;
                    r_key_len   <= (w_count_inc == '0) ? KEY_CW'(1) : w_count_inc;
                    r_n         <= '0;
                    r_j         <= '0;
                    r_k         <= '0;
                end else begin
                    r_key_count <= w_count_inc;
                end
            end
            if (i_cmd.fill_step) begin
                r_n <= r_n + 8'd1;
            end
            if (i_cmd.ks_b) begin
                r_j <= r_j + w_p_rdata + w_k_rdata;
            end
            if (i_cmd.ks_d) begin
                r_n <= r_n + 8'd1;
                if (({1'b0, r_k} + KEY_CW'(1)) == r_key_len) begin
                    r_k <= '0;
                end else begin
                    r_k <= r_k + KEY_AW'(1);
                end
            end
            if (i_cmd.clr_ij) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (i_cmd.pr_a) begin
                r_i <= r_i + 8'd1;
            end
            if (i_cmd.pr_b) begin
                r_j <= r_j + w_p_rdata;
            end
            if (i_cmd.out_load_ks || i_cmd.out_load_res) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ks_b || i_cmd.pr_b) begin
            r_sa <= w_p_rdata;
        end
        if (i_cmd.pr_c) begin
            r_sb <= w_p_rdata;
            r_t  <= r_sa + w_p_rdata;
        end
        if (i_cmd.accept_data) begin
            r_data <= i_byte_in;
        end
        if (i_cmd.nokey_res) begin
            r_res    <= 8'h00;
            r_res_nk <= 1'b1;
        end else if (i_cmd.res_save) begin
            r_res    <= w_ks_result;
            r_res_nk <= 1'b0;
        end
        if (i_cmd.out_load_ks) begin
            o_byte_out <= w_ks_result;
            o_no_key   <= 1'b0;
        end else if (i_cmd.out_load_res) begin
            o_byte_out <= r_res;
            o_no_key   <= r_res_nk;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rc4_drop_stream_cipher.sv =====
// Top level of the RC4-drop stream cipher: controller plus datapath.
// Depends on rc4d_pkg, rc4d_ctrl, rc4d_dp and rc4d_ram.
//
//   Channel  Direction  Handshake                Payload
//   in       into block i_in_valid / o_in_stall  i_cmd, i_byte_in, i_key_last
//   out      from block o_out_valid / i_out_stall o_byte_out, o_no_key
//   cfg      into block i_cfg_wr_en              i_cfg_wr_data (drop count)
//
// The block takes key beats back to back. After a data beat it stalls the
// input through the keystream step, states PR_A to PR_D, which shares the
// single permutation memory with its one read and one write port.
// The last key beat starts setup: identity fill, key schedule and
// drop_count discarded keystream steps.
// Reset is synchronous and active low; it clears the state machine, the key
// count, the drop count (to 1024) and the output stage. No clearing pass runs.
// A result waits in the output register while the output is stalled; a
// second data result parks in the datapath until the output register frees.
`default_nettype none

module rc4_drop_stream_cipher
    import rc4d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input channel.
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_cmd,
    input  wire logic [7:0]        i_byte_in,
    input  wire logic              i_key_last,
    // Output channel.
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_byte_out,
    output logic                   o_no_key,
    // Drop count register.
    input  wire logic              i_cfg_wr_en,
    input  wire logic [DROP_W-1:0] i_cfg_wr_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller sequences fill, key schedule, drop and each keystream
    // step; it owns the drop count register and the key-ready flag.
    rc4d_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_cmd         (i_cmd),
        .i_key_last    (i_key_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sts         (w_sts),
        .o_in_stall    (o_in_stall),
        .o_cmd         (w_cmd)
    );

    // The datapath holds both memories, the indices and the output stage.
    rc4d_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_byte_in   (i_byte_in),
        .i_key_last  (i_key_last),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_byte_out  (o_byte_out),
        .o_no_key    (o_no_key)
    );

endmodule

`default_nettype wire

// ===== rtl/rc4d_checker.sv =====
// Port-level checker for the RC4-drop stream cipher, bound to the top level.
// Depends on rc4d_pkg.
`default_nettype none

module rc4d_checker
    import rc4d_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              i_cmd,
    input wire logic [7:0]        i_byte_in,
    input wire logic              i_key_last,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [7:0]        o_byte_out,
    input wire logic              o_no_key,
    input wire logic              i_cfg_wr_en,
    input wire logic [DROP_W-1:0] i_cfg_wr_data
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_out)
            && $stable(o_no_key))
        else $error("stalled output beat changed");

    // A result made before any key carries a zero byte.
    a_nokey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_key |-> o_byte_out == 8'h00)
        else $error("no-key result with nonzero byte");

    // A data beat occupies the block for its keystream step.
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_cmd == CMD_DATA |=> o_in_stall)
        else $error("input taken during keystream step");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind rc4_drop_stream_cipher rc4d_checker u_rc4d_checker (.*);

`default_nettype wire
